FILE: rtl/core/sha1_pkg.sv
// Package for the SHA-1 digest block: codes, constants and round helpers.
// No dependencies.
package sha1_pkg;
  localparam logic [1:0] MODE_ABSORB = 2'd0;
  localparam logic [1:0] MODE_LAST   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;

  typedef struct packed {
    logic        start;
    logic [31:0] w;
    logic [6:0]  rnd;
  } round_ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r,
      input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)      f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction
endpackage

FILE: rtl/core/sha1_if.sv
// Valid/ready channel interfaces for the SHA-1 block.
// Depends on nothing.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] message_byte;
  modport source (output valid, mode, message_byte, input ready);
  modport sink (input valid, mode, message_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/sha1_message_digest_top.sv
// SHA-1 digest top level: byte packing, padding sequencer, schedule and output.
// Depends on sha1_pkg, sha1_if and sha1_round.
//
// One item is one byte (or an end mark). A byte is written straight into the
// window; one that fills a 64-byte block then starts a compression: a load,
// 80 rounds through the single shared round unit and a chain update.
// Finishing feeds 0x80, zero fill and the 8 length bytes through the same
// path one byte per cycle (plus one or two compressions), then shows the five
// digest words one at a time on the output register; the next item is
// accepted once the last word is taken. The schedule lives in a 16-word
// window rewritten in place, so no memory clearing is needed at reset.
module sha1_message_digest_top (
  input logic clk,
  input logic rst,
  sha1_in_if.sink   in_ch,
  sha1_out_if.source out_ch
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT} state_t;
  state_t state;

  logic [31:0]  chain [5];
  logic [31:0]  sched [16];
  logic [5:0]   fill;
  logic [63:0]  bit_len;
  logic [63:0]  len_hold;
  logic [6:0]   rnd;
  logic [3:0]   pad_cnt;    // 0: pad byte, 1: zero fill, 2..9: length bytes, 10: done
  logic         finishing;
  logic [2:0]   widx;
  logic [159:0] vars;
  round_ctl_t   ctl;
  logic [31:0]  w_calc;
  logic [31:0]  w_now;
  logic [7:0]   pad_byte;
  logic         put;
  logic [7:0]   put_val;

  // Schedule word for this round.
  assign w_calc = sched[rnd[3:0] + 4'd13] ^ sched[rnd[3:0] + 4'd8]
                ^ sched[rnd[3:0] + 4'd2] ^ sched[rnd[3:0]];
  assign w_now  = (rnd < 7'd16) ? sched[rnd[3:0]] : {w_calc[30:0], w_calc[31]};
  assign ctl = '{start: (state == S_ROUND), w: w_now, rnd: rnd};

  sha1_round u_round (
    .clk  (clk),
    .load (state == S_LOAD),
    .init ({chain[0], chain[1], chain[2], chain[3], chain[4]}),
    .ctl  (ctl),
    .vars (vars)
  );

  // Pad byte: 0x80 first, zeros until LEN_POS, then length big-endian.
  always_comb begin
    if (pad_cnt == 4'd0)      pad_byte = PAD_BYTE;
    else if (pad_cnt == 4'd1) pad_byte = 8'h00;
    else                      pad_byte = len_hold[8'd79 - {pad_cnt, 3'b000} -: 8];
  end

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign put = (state == S_IDLE && in_ch.valid && (in_ch.mode == MODE_ABSORB
               || in_ch.mode == MODE_LAST)) || (state == S_PAD);
  assign put_val = (state == S_PAD) ? pad_byte : in_ch.message_byte;

  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.digest_word = chain[widx];
  assign out_ch.word_index  = widx;
  assign out_ch.last_word   = (widx == 3'd4);

  // Schedule window: write bytes in, and rewrite words during rounds.
  always_ff @(posedge clk) begin
    if (put) begin
      sched[fill[5:2]][5'd24 - {fill[1:0], 3'b000} +: 8] <= put_val;
    end else if (state == S_ROUND && rnd >= 7'd16) begin
      sched[rnd[3:0]] <= w_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chain <= '{H0, H1, H2, H3, H4};
      fill <= '0;
      bit_len <= '0;
      rnd <= '0;
      pad_cnt <= '0;
      finishing <= 1'b0;
      widx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            len_hold <= bit_len + ((in_ch.mode == MODE_FINISH) ? 64'd0 : 64'd8);
            pad_cnt <= '0;
            if (in_ch.mode != MODE_NONE && in_ch.mode != MODE_FINISH) begin
              bit_len <= bit_len + 64'd8;
              fill <= fill + 6'd1;
            end
            finishing <= (in_ch.mode == MODE_LAST || in_ch.mode == MODE_FINISH);
            if (put && fill == 6'd63) begin
              state <= S_LOAD;
            end else if (in_ch.mode == MODE_LAST || in_ch.mode == MODE_FINISH) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill <= fill + 6'd1;
          // advance: after 0x80, hold zero until LEN_POS, then step length bytes
          if (pad_cnt == 4'd0) pad_cnt <= ((fill + 6'd1) == LEN_POS) ? 4'd2 : 4'd1;
          else if (pad_cnt == 4'd1) pad_cnt <= ((fill + 6'd1) == LEN_POS) ? 4'd2 : 4'd1;
          else pad_cnt <= pad_cnt + 4'd1;
          if (fill == 6'd63) state <= S_LOAD;
        end
        S_LOAD: begin
          rnd <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_ADD;
        end
        S_ADD: begin
          rnd <= '0;
          chain[0] <= chain[0] + vars[159:128];
          chain[1] <= chain[1] + vars[127:96];
          chain[2] <= chain[2] + vars[95:64];
          chain[3] <= chain[3] + vars[63:32];
          chain[4] <= chain[4] + vars[31:0];
          if (!finishing) state <= S_IDLE;
          else if (pad_cnt == 4'd10) begin
            widx <= '0;
            state <= S_OUT;
          end else state <= S_PAD;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd4) begin
              chain <= '{H0, H1, H2, H3, H4};
              fill <= '0;
              bit_len <= '0;
              finishing <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/sha1_round.sv
// Shared SHA-1 round unit: working variables a..e, one round per start.
// Depends on sha1_pkg.
module sha1_round (
  input  logic                   clk,
  input  logic                   load,
  input  logic [159:0]           init,
  input  sha1_pkg::round_ctl_t   ctl,
  output logic [159:0]           vars
);
  import sha1_pkg::*;
  logic [31:0] a, b, c, d, e, t;
  assign vars = {a, b, c, d, e};
  assign t = {a[26:0], a[31:27]} + e + ctl.w + round_f(ctl.rnd, b, c, d) + round_k(ctl.rnd);
  always_ff @(posedge clk) begin
    if (load) begin
      {a, b, c, d, e} <= init;
    end else if (ctl.start) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end
endmodule

FILE: rtl/core/sha1_checker.sv
// Port-level checks for the SHA-1 digest top level, with its bind.
// Depends on sha1_message_digest_top port names.
module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_index,
  input logic        out_last
);
  // Output stays stable while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_index))
    else $error("stalled digest word changed");
  // Last flag marks index four only.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == 3'd4)))
    else $error("last flag mismatch");
  // Never take input while a digest is being shown.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during output");
  // Index steps by one after a taken non-last word.
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid && out_index == $past(out_index) + 3'd1)
    else $error("word index skipped");
endmodule

bind sha1_message_digest_top sha1_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_word(out_ch.digest_word),
  .out_index(out_ch.word_index), .out_last(out_ch.last_word)
);

FILE: tb/sha1_tb_checker.sv
// Digest checker for the SHA-1 block: watches both channels, predicts digests.
// Depends on sha1_pkg.
module sha1_tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_word,
  input  logic [2:0]  out_index,
  input  logic        out_last,
  output int          fail_count,
  output int          words_pending
);
  import sha1_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [31:0] chain[5];
  logic [31:0] blk[16];
  logic [5:0]  fill;
  logic [63:0] nbits;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        x = w[r];
      end else begin
        x = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
        w[r % 16] = x;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + e + x + f + k;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic push_byte(input logic [7:0] v);
    blk[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] = v;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endtask

  task automatic start_message();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    fill = '0;
    nbits = '0;
  endtask

  task automatic absorb(input logic [1:0] mode, input logic [7:0] v);
    logic [63:0] len;
    digest_word_t dw;
    if (mode == MODE_NONE) return;
    if (mode != MODE_FINISH) begin
      push_byte(v);
      nbits = nbits + 64'd8;
    end
    if (mode == MODE_ABSORB) return;
    len = nbits;
    push_byte(PAD_BYTE);
    while (fill != LEN_POS) push_byte(8'h00);
    for (int i = 0; i < 8; i++) push_byte(len[(7 - i) * 8 +: 8]);
    for (int i = 0; i < 5; i++) begin
      dw.word = chain[i];
      dw.index = 3'(i);
      dw.last = (i == 4);
      digest_q.push_back(dw);
    end
    start_message();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    words_pending = 0;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    start_message();
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst) begin
      if (in_valid && in_ready) absorb(in_mode, in_byte);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report("unexpected word", out_word, 32'h0);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_word !== exp_w.word) report("digest_word", out_word, exp_w.word);
          if (out_index !== exp_w.index) report("word_index", out_index, exp_w.index);
          if (out_last !== exp_w.last) report("last_word", out_last, exp_w.last);
        end
      end
    end
    words_pending = digest_q.size();
  end
endmodule

FILE: tb/sha1_message_digest_top_tb.sv
// Top of the SHA-1 digest testbench: clock, reset, byte stimulus and verdict.
// Depends on sha1_pkg, sha1_if, sha1_tb_checker and the block itself.
module sha1_message_digest_top_tb;
  import sha1_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   words_pending;
  int   quiet_cycles = 0;
  logic no_idle = 1'b0;
  logic hold_off = 1'b0;
  logic sending_done = 1'b0;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_message_digest_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_tb_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_mode       (in_ch.mode),
    .in_byte       (in_ch.message_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_word      (out_ch.digest_word),
    .out_index     (out_ch.word_index),
    .out_last      (out_ch.last_word),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ABSORB;
    in_ch.message_byte = 8'h00;
    out_ch.ready = 1'b0;
  end

  // Drain side: random back-pressure, except during the quiet stretch or a hold-off.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  // Long receiver hold-off so the block fills up and stops taking items.
  initial begin
    @(posedge clk iff !rst);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Send one item: idle at random first, then hold valid until it is taken.
  task automatic send(input logic [1:0] mode, input logic [7:0] v);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.message_byte <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Well-formed message: len bytes of random content, then an end item.
  task automatic send_message(input int len, input logic [1:0] ender);
    for (int i = 0; i < len; i++) send(MODE_ABSORB, 8'($urandom));
    if (ender == MODE_LAST) send(MODE_LAST, 8'($urandom));
    else send(MODE_FINISH, 8'($urandom));
  endtask

  initial begin
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty message, extremes of the byte, the unused mode, short tails.
    send(MODE_FINISH, 8'hFF);
    send(MODE_LAST, 8'h00);
    send(MODE_LAST, 8'hFF);
    send(MODE_NONE, 8'hA5);
    send(MODE_ABSORB, 8'hFF);
    send(MODE_NONE, 8'h5A);
    send(MODE_FINISH, 8'h00);
    send(MODE_ABSORB, 8'h61);
    send(MODE_ABSORB, 8'h62);
    send(MODE_LAST, 8'h63);
    // Tail past byte 55 forces an extra length block; 64 bytes end on a block edge.
    send_message(56, MODE_FINISH);
    send_message(63, MODE_LAST);
    // Full block and its digest with no idling on either side.
    no_idle <= 1'b1;
    send_message(64, MODE_FINISH);
    no_idle <= 1'b0;
    // Random part: short messages, stray end marks and the unused mode.
    for (int m = 0; m < 12; m++) begin
      len = $urandom_range(3);
      case ($urandom_range(9))
        0: send(MODE_NONE, 8'($urandom));
        1: send(MODE_FINISH, 8'($urandom));
        default: send_message(len, ($urandom_range(1) == 0) ? MODE_LAST : MODE_FINISH);
      endcase
    end
    in_ch.valid <= 1'b0;
    sending_done <= 1'b1;
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Verdict once everything has drained, plus a tail for stray outputs.
  initial begin
    @(posedge clk iff sending_done);
    while (words_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
